>>> rtl/core/ttps_pkg.sv
package ttps_pkg;

    localparam int unsigned ENTRIES_DEF = 65536;

    localparam int unsigned DEPTH_W = 9;
    localparam int unsigned SCORE_W = 32;
    localparam int unsigned SDEPTH_W = 8;

    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_PROBE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_EXACT  = 2'd0,
        KIND_UPPER  = 2'd1,
        KIND_LOWER  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    localparam logic signed [DEPTH_W-1:0] EMPTY_DEPTH = -9'sd1;

    typedef struct packed {
        logic signed [DEPTH_W-1:0] depth;
        logic signed [SCORE_W-1:0] score;
        logic [1:0]                kind;
    } entry_t;

    typedef struct packed {
        logic                      hit;
        logic signed [SCORE_W-1:0] value;
        logic                      same_parity;
        logic                      store_wr;
    } res_t;

endpackage

>>> rtl/core/ttps_store.sv
module ttps_store #(
    parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF,
    parameter int unsigned IDX_W = $clog2(ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output ttps_pkg::entry_t     rd_data,
    input  logic                 depth_we,
    input  logic                 data_we,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ttps_pkg::entry_t     wr_data
);
    import ttps_pkg::*;

    logic signed [DEPTH_W-1:0] depth_mem [ENTRIES];
    logic [SCORE_W+1:0]        data_mem [ENTRIES];

    logic signed [DEPTH_W-1:0] depth_rd_reg;
    logic [SCORE_W+1:0]        data_rd_reg;

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[wr_addr] <= wr_data.depth;
        end
        if (rd_en)
        begin
            depth_rd_reg <= depth_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[wr_addr] <= {wr_data.score, wr_data.kind};
        end
        if (rd_en)
        begin
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    assign rd_data.depth = depth_rd_reg;
    assign rd_data.score = data_rd_reg[SCORE_W+1:2];
    assign rd_data.kind  = data_rd_reg[1:0];

endmodule

>>> rtl/core/ttps_clear.sv
module ttps_clear #(
    parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF,
    parameter int unsigned IDX_W = $clog2(ENTRIES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             active,
    output logic [IDX_W-1:0] idx
);
    import ttps_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic             active_reg;
    logic             active_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        if (active_reg)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg == LAST_IDX)
            begin
                active_next = 1'b0;
                idx_next    = '0;
            end
        end
        else if (start)
        begin
            active_next = 1'b1;
            idx_next    = '0;
        end
    end

    // sweep runs straight out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    assign active = active_reg;
    assign idx    = idx_reg;

endmodule

>>> rtl/core/ttps_resolve.sv
module ttps_resolve (
    input  logic [1:0]                          cmd,
    input  logic [ttps_pkg::SDEPTH_W-1:0]       search_depth,
    input  logic signed [ttps_pkg::SCORE_W-1:0] alpha,
    input  logic signed [ttps_pkg::SCORE_W-1:0] beta,
    input  ttps_pkg::entry_t                    cur,
    output ttps_pkg::res_t                      res
);
    import ttps_pkg::*;

    logic signed [DEPTH_W-1:0] asked;
    logic                      deep_enough;
    logic                      not_deeper;

    always_comb
    begin
        asked       = $signed({1'b0, search_depth});
        deep_enough = ($signed(cur.depth) >= asked);
        not_deeper  = ($signed(cur.depth) <= asked);

        res.hit         = 1'b0;
        res.value       = '0;
        res.store_wr    = 1'b0;
        // empty slot reads as -1, which counts as odd
        res.same_parity = ~(cur.depth[0] ^ search_depth[0]);

        case (cmd)
            CMD_STORE:
            begin
                res.store_wr = not_deeper;
            end
            CMD_PROBE:
            begin
                if (deep_enough)
                begin
                    case (cur.kind)
                        KIND_EXACT:
                        begin
                            res.hit   = 1'b1;
                            res.value = cur.score;
                        end
                        KIND_UPPER:
                        begin
                            if ($signed(cur.score) <= alpha)
                            begin
                                res.hit   = 1'b1;
                                res.value = alpha;
                            end
                        end
                        KIND_LOWER:
                        begin
                            if ($signed(cur.score) >= beta)
                            begin
                                res.hit   = 1'b1;
                                res.value = beta;
                            end
                        end
                        default:
                        begin
                            res.hit = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                res.store_wr = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/transposition_table_probe_store_core.sv
// Direct-mapped transposition table with depth-preferred replacement. The slot is
// key mod ENTRIES (low key bits, no key check, so colliding keys alias). Each item
// is a read-modify-write: the tables are read the cycle the item is taken, the
// result is formed and any store written back as the item moves from the read
// stage to the output register, and a write is forwarded to a following item on
// the same slot, so store and probe items go through at one per cycle while
// results are taken. A clear item reports its slot as usual, then walks the depth
// table writing empty at one slot per cycle, and no item is taken until the walk
// is done. The same clearing pass runs after reset before the first item is taken.
module transposition_table_probe_store_core #(
    parameter int unsigned ENTRIES = ttps_pkg::ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [63:0]                         key,
    input  logic signed [ttps_pkg::SCORE_W-1:0] score,
    input  logic [ttps_pkg::SDEPTH_W-1:0]       search_depth,
    input  logic [1:0]                          bound_kind,
    input  logic signed [ttps_pkg::SCORE_W-1:0] alpha,
    input  logic signed [ttps_pkg::SCORE_W-1:0] beta,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic signed [ttps_pkg::SCORE_W-1:0] value,
    output logic signed [ttps_pkg::DEPTH_W-1:0] stored_depth,
    output logic                                same_parity
);
    import ttps_pkg::*;

    localparam int unsigned IDX_W = $clog2(ENTRIES);

    // read stage (item waiting on table data)
    logic                      b_valid_reg, b_valid_next;
    logic [1:0]                b_cmd_reg;
    logic [IDX_W-1:0]          b_idx_reg;
    logic signed [SCORE_W-1:0] b_score_reg;
    logic [SDEPTH_W-1:0]       b_depth_reg;
    logic [1:0]                b_kind_reg;
    logic signed [SCORE_W-1:0] b_alpha_reg;
    logic signed [SCORE_W-1:0] b_beta_reg;

    // last write back, for a following item on the same slot
    logic                      fwd_valid_reg, fwd_valid_next;
    logic [IDX_W-1:0]          fwd_idx_reg;
    entry_t                    fwd_entry_reg;

    // output register
    logic                      out_valid_reg, out_valid_next;
    logic                      hit_reg;
    logic signed [SCORE_W-1:0] value_reg;
    logic signed [DEPTH_W-1:0] stored_depth_reg;
    logic                      same_parity_reg;

    logic                      accept;
    logic                      out_free;
    logic                      b_advance;
    logic                      clear_start;
    logic                      sweep_active;
    logic [IDX_W-1:0]          sweep_idx;
    entry_t                    rd_data;
    entry_t                    cur;
    entry_t                    new_entry;
    entry_t                    wr_data;
    res_t                      res;
    logic                      depth_we;
    logic                      data_we;
    logic [IDX_W-1:0]          wr_addr;

    assign out_free    = !out_valid_reg || out_ready;
    assign b_advance   = b_valid_reg && out_free;
    assign clear_start = b_advance && (b_cmd_reg == CMD_CLEAR);
    // a clear in flight holds off new items until its sweep is done
    assign in_ready    = !sweep_active
                         && !(b_valid_reg && (b_cmd_reg == CMD_CLEAR))
                         && (!b_valid_reg || out_free);
    assign accept      = in_valid && in_ready;

    assign cur = (fwd_valid_reg && (fwd_idx_reg == b_idx_reg)) ? fwd_entry_reg : rd_data;

    ttps_resolve u_resolve (
        .cmd          (b_cmd_reg),
        .search_depth (b_depth_reg),
        .alpha        (b_alpha_reg),
        .beta         (b_beta_reg),
        .cur          (cur),
        .res          (res)
    );

    always_comb
    begin
        new_entry.depth = $signed({1'b0, b_depth_reg});
        new_entry.score = b_score_reg;
        new_entry.kind  = b_kind_reg;
    end

    always_comb
    begin
        depth_we = sweep_active || (b_advance && res.store_wr);
        data_we  = b_advance && res.store_wr;
        wr_addr  = sweep_active ? sweep_idx : b_idx_reg;
        wr_data  = new_entry;
        if (sweep_active)
        begin
            wr_data.depth = EMPTY_DEPTH;
        end
    end

    ttps_store #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk      (clk),
        .rd_en    (accept),
        .rd_addr  (key[IDX_W-1:0]),
        .rd_data  (rd_data),
        .depth_we (depth_we),
        .data_we  (data_we),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    ttps_clear #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_clear (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (clear_start),
        .active (sweep_active),
        .idx    (sweep_idx)
    );

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (accept)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_advance)
        begin
            b_valid_next = 1'b0;
        end

        fwd_valid_next = fwd_valid_reg;
        if (b_advance)
        begin
            fwd_valid_next = res.store_wr;
        end

        out_valid_next = out_valid_reg;
        if (b_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_cmd_reg   <= cmd;
            b_idx_reg   <= key[IDX_W-1:0];
            b_score_reg <= score;
            b_depth_reg <= search_depth;
            b_kind_reg  <= bound_kind;
            b_alpha_reg <= alpha;
            b_beta_reg  <= beta;
        end
        if (b_advance)
        begin
            fwd_idx_reg      <= b_idx_reg;
            fwd_entry_reg    <= new_entry;
            hit_reg          <= res.hit;
            value_reg        <= res.value;
            stored_depth_reg <= cur.depth;
            same_parity_reg  <= res.same_parity;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign value        = value_reg;
    assign stored_depth = stored_depth_reg;
    assign same_parity  = same_parity_reg;

endmodule
